### hdl/aarm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_pkg
// Types, constants and small arithmetic helpers shared by the rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package aarm_pkg;

    // request kinds
    typedef enum logic {
        OP_AXIS  = 1'b0,
        OP_EULER = 1'b1
    } t_op;

    localparam int unsigned CORDIC_STEPS = 17;
    localparam int unsigned SQRT_STEPS   = 32;
    localparam int unsigned DIV_STEPS    = 17;

    // Q.16 working value, range +-1.0
    typedef logic signed [17:0] t_q16;
    // matrix entry before output scaling
    typedef logic signed [19:0] t_ent;

    localparam logic signed [31:0] CORDIC_K = 32'sd652032874;
    localparam logic signed [18:0] HALF_PI  = 19'sd102944;
    localparam logic signed [18:0] PI_Q16   = 19'sd205887;
    localparam t_q16                ONE      = 18'sd65536;
    localparam logic signed [15:0]  OUT_LIM  = 16'sd16384;

    typedef struct packed {
        t_op                op;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
        logic signed [15:0] angle;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] row0_col0;
        logic signed [15:0] row0_col1;
        logic signed [15:0] row0_col2;
        logic signed [15:0] row1_col0;
        logic signed [15:0] row1_col1;
        logic signed [15:0] row1_col2;
        logic signed [15:0] row2_col0;
        logic signed [15:0] row2_col1;
        logic signed [15:0] row2_col2;
    } t_out_beat;

    typedef struct packed {
        t_q16 s;
        t_q16 c;
    } t_sincos;

    // sine/cosine of the three angle lanes
    typedef struct packed {
        t_sincos sc0;
        t_sincos sc1;
        t_sincos sc2;
    } t_sc3;

    // normalized axis
    typedef struct packed {
        t_q16 x;
        t_q16 y;
        t_q16 z;
    } t_nvec;

    // atan(2^-i) in units of 2^-16 rad
    function automatic logic [15:0] atan_lut(input int unsigned idx);
        logic [15:0] v;
        case (idx)
            0:       v = 16'd51472;
            1:       v = 16'd30386;
            2:       v = 16'd16055;
            3:       v = 16'd8150;
            4:       v = 16'd4091;
            5:       v = 16'd2047;
            6:       v = 16'd1024;
            7:       v = 16'd512;
            8:       v = 16'd256;
            9:       v = 16'd128;
            10:      v = 16'd64;
            11:      v = 16'd32;
            12:      v = 16'd16;
            13:      v = 16'd8;
            14:      v = 16'd4;
            15:      v = 16'd2;
            16:      v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // saturate to +-1.0 in Q.16
    function automatic t_q16 clamp_q16(input logic signed [32:0] v);
        t_q16 r;
        if (v > 33'sd65536) begin
            r = ONE;
        end else if (v < -33'sd65536) begin
            r = -ONE;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    // Q.16 product, rounded half up
    function automatic t_ent mulq(input t_ent a, input t_ent b);
        logic signed [39:0] p;
        p = a * b;
        p = p + 40'sd32768;
        p = p >>> 16;
        return p[19:0];
    endfunction

    // Q.16 to Q2.14, rounded and saturated
    function automatic logic signed [15:0] sat_out(input t_ent v);
        logic signed [20:0] w;
        logic signed [15:0] r;
        w = 21'(v) + 21'sd2;
        w = w >>> 2;
        if (w > 21'sd16384) begin
            r = OUT_LIM;
        end else if (w < -21'sd16384) begin
            r = -OUT_LIM;
        end else begin
            r = w[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/aarm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_if
// Valid/ready channels for rotation requests and matrix results.
// ----------------------------------------------------------------------------
interface aarm_in_if;
    import aarm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface aarm_out_if;
    import aarm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/axis_angle_rotation_matrix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Takes one rotation request per cycle and returns the 3x3 rotation part of
// a homogeneous matrix in Q2.14. Op 0 normalizes the Q4.12 axis and builds
// the Rodrigues matrix from CORDIC sine and cosine of the Q3.13 angle; a
// zero axis gives cosine on the diagonal. Op 1 returns Rz(vec_z) *
// Ry(vec_x) * Rx(vec_y). The pipeline accepts a beat every cycle while it
// is not stalled; the longest path runs through the 32-stage square root
// followed by the 19-stage normalizing divider. The pipeline stalls as a
// whole while its last stage holds a beat that the output register cannot
// take; while the last stage is empty, beats move up behind a waiting result.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aarm_in_if.sink     i_in,
    aarm_out_if.source  o_out
);
    import aarm_pkg::*;

    // pipeline depth at which each value becomes available
    localparam int unsigned D_IN   = 1;
    localparam int unsigned D_Q    = 2;
    localparam int unsigned D_SC   = 20;
    localparam int unsigned D_ROOT = 34;
    localparam int unsigned D_N    = 53;
    localparam int unsigned D_M    = 57;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_vec3;

    logic               w_en;
    logic               w_out_ld;
    logic               r_vld [D_IN:D_M];
    t_in_beat           r_in;

    logic signed [31:0] w_px, w_py, w_pz;
    logic signed [32:0] w_sum;
    logic        [31:0] r_q;

    t_vec3              r_vd  [D_Q:D_ROOT];
    t_op                r_op  [D_Q:D_N];
    t_sc3               r_scd [D_SC+1:D_N];

    logic signed [15:0] w_ang0;
    t_sc3               w_sc;
    logic        [31:0] w_root;
    t_nvec              w_n;
    t_ent               w_m [9];

    t_out_beat          n_out;
    t_out_beat          r_out;
    logic               r_out_valid;

    // stall control: output register parts the sides, bubbles squeeze out
    assign w_out_ld  = !r_out_valid || o_out.ready;
    assign w_en      = !r_vld[D_M] || w_out_ld;
    assign i_in.ready = w_en;

    // valid bits travel with the beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = D_IN; d <= D_M; d++) begin
                r_vld[d] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[D_IN] <= i_in.valid;
            for (int d = D_IN; d < D_M; d++) begin
                r_vld[d+1] <= r_vld[d];
            end
        end
    end

    // input register and squared length
    assign w_px  = r_in.vec_x * r_in.vec_x;
    assign w_py  = r_in.vec_y * r_in.vec_y;
    assign w_pz  = r_in.vec_z * r_in.vec_z;
    assign w_sum = 33'(w_px) + 33'(w_py) + 33'(w_pz);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_in.data;
            r_q  <= w_sum[31:0];
        end
    end

    // side delay lines
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vd[D_Q] <= '{x: r_in.vec_x, y: r_in.vec_y, z: r_in.vec_z};
            for (int d = D_Q; d < D_ROOT; d++) begin
                r_vd[d+1] <= r_vd[d];
            end
            r_op[D_Q] <= r_in.op;
            for (int d = D_Q; d < D_N; d++) begin
                r_op[d+1] <= r_op[d];
            end
            r_scd[D_SC+1] <= w_sc;
            for (int d = D_SC + 1; d < D_N; d++) begin
                r_scd[d+1] <= r_scd[d];
            end
        end
    end

    // angle lanes: lane 0 carries the axis-angle or the x-rotation angle
    assign w_ang0 = (r_in.op == OP_EULER) ? r_in.vec_y : r_in.angle;

    aarm_cordic u_cordic0 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_ang0),
        .o_sc    (w_sc.sc0)
    );

    aarm_cordic u_cordic1 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_in.vec_x),
        .o_sc    (w_sc.sc1)
    );

    aarm_cordic u_cordic2 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_in.vec_z),
        .o_sc    (w_sc.sc2)
    );

    // vector length in Q.16
    aarm_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_q    (r_q),
        .o_root (w_root)
    );

    // normalize each component
    aarm_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (r_vd[D_ROOT].x),
        .i_r   (w_root),
        .o_n   (w_n.x)
    );

    aarm_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (r_vd[D_ROOT].y),
        .i_r   (w_root),
        .o_n   (w_n.y)
    );

    aarm_div u_div_z (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (r_vd[D_ROOT].z),
        .i_r   (w_root),
        .o_n   (w_n.z)
    );

    aarm_rot u_rot (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_op  (r_op[D_N]),
        .i_n   (w_n),
        .i_sc  (r_scd[D_N]),
        .o_m   (w_m)
    );

    // output scaling and output register
    always_comb begin
        n_out.row0_col0 = sat_out(w_m[0]);
        n_out.row0_col1 = sat_out(w_m[1]);
        n_out.row0_col2 = sat_out(w_m[2]);
        n_out.row1_col0 = sat_out(w_m[3]);
        n_out.row1_col1 = sat_out(w_m[4]);
        n_out.row1_col2 = sat_out(w_m[5]);
        n_out.row2_col0 = sat_out(w_m[6]);
        n_out.row2_col1 = sat_out(w_m[7]);
        n_out.row2_col2 = sat_out(w_m[8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_out_valid <= r_vld[D_M];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
`default_nettype wire

### hdl/aarm_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_cordic
// Pipelined rotation-mode CORDIC: half-turn reduction, 17 micro-rotations,
// sign fix and rounding to Q.16.
// ----------------------------------------------------------------------------
module aarm_cordic (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_angle,
    output aarm_pkg::t_sincos   o_sc
);
    import aarm_pkg::*;

    logic signed [18:0] w_z8;
    logic signed [18:0] n_z0;
    logic               n_neg0;
    logic signed [18:0] r_z0;
    logic               r_neg0;

    logic signed [31:0] r_x   [CORDIC_STEPS];
    logic signed [31:0] r_y   [CORDIC_STEPS];
    logic signed [18:0] r_z   [CORDIC_STEPS];
    logic               r_neg [CORDIC_STEPS];

    logic signed [32:0] w_xf;
    logic signed [32:0] w_yf;
    t_sincos            r_sc;

    // angle in 2^-16 rad, folded into +-pi/2
    assign w_z8 = {i_angle, 3'b000};

    always_comb begin
        n_z0   = w_z8;
        n_neg0 = 1'b0;
        if (w_z8 > HALF_PI) begin
            n_z0   = w_z8 - PI_Q16;
            n_neg0 = 1'b1;
        end else if (w_z8 < -HALF_PI) begin
            n_z0   = w_z8 + PI_Q16;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0   <= n_z0;
            r_neg0 <= n_neg0;
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [18:0] a_z;
        logic               a_neg;
        logic signed [18:0] w_atan;
        logic signed [31:0] n_x;
        logic signed [31:0] n_y;
        logic signed [18:0] n_z;

        if (i == 0) begin : g_first
            assign a_x   = CORDIC_K;
            assign a_y   = '0;
            assign a_z   = r_z0;
            assign a_neg = r_neg0;
        end else begin : g_next
            assign a_x   = r_x[i-1];
            assign a_y   = r_y[i-1];
            assign a_z   = r_z[i-1];
            assign a_neg = r_neg[i-1];
        end

        assign w_atan = {3'b000, atan_lut(i)};

        always_comb begin
            if (a_z >= 19'sd0) begin
                n_x = a_x - (a_y >>> i);
                n_y = a_y + (a_x >>> i);
                n_z = a_z - w_atan;
            end else begin
                n_x = a_x + (a_y >>> i);
                n_y = a_y - (a_x >>> i);
                n_z = a_z + w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i]   <= n_x;
                r_y[i]   <= n_y;
                r_z[i]   <= n_z;
                r_neg[i] <= a_neg;
            end
        end
    end

    // undo the half-turn, then round from Q.30 to Q.16
    assign w_xf = r_neg[CORDIC_STEPS-1] ? -33'(r_x[CORDIC_STEPS-1]) : 33'(r_x[CORDIC_STEPS-1]);
    assign w_yf = r_neg[CORDIC_STEPS-1] ? -33'(r_y[CORDIC_STEPS-1]) : 33'(r_y[CORDIC_STEPS-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc.c <= clamp_q16((w_xf + 33'sd8192) >>> 14);
            r_sc.s <= clamp_q16((w_yf + 33'sd8192) >>> 14);
        end
    end

    assign o_sc = r_sc;

endmodule
`default_nettype wire

### hdl/aarm_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_sqrt
// Pipelined digit-by-digit square root of q * 2^32, one root bit per stage.
// ----------------------------------------------------------------------------
module aarm_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_q,
    output logic [31:0] o_root
);
    import aarm_pkg::*;

    logic [32:0] r_rem  [SQRT_STEPS];
    logic [31:0] r_root [SQRT_STEPS];
    logic [31:0] r_num  [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [32:0] a_rem;
        logic [31:0] a_root;
        logic [31:0] a_num;
        logic [34:0] w_t;
        logic [34:0] w_d;
        logic [32:0] n_rem;
        logic [31:0] n_root;
        logic [31:0] n_num;

        if (k == 0) begin : g_first
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_num  = i_q;
        end else begin : g_next
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
            assign a_num  = r_num[k-1];
        end

        // bring down the next bit pair, try root*4+1
        assign w_t = {a_rem, a_num[31:30]};
        assign w_d = {1'b0, a_root, 2'b01};

        always_comb begin
            n_num = {a_num[29:0], 2'b00};
            if (w_t >= w_d) begin
                n_rem  = 33'(w_t - w_d);
                n_root = {a_root[30:0], 1'b1};
            end else begin
                n_rem  = w_t[32:0];
                n_root = {a_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_num[k]  <= n_num;
            end
        end
    end

    assign o_root = r_root[SQRT_STEPS-1];

endmodule
`default_nettype wire

### hdl/aarm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_div
// One axis component divided by the vector length: rounded restoring
// division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aarm_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_v,
    input  logic        [31:0] i_r,
    output aarm_pkg::t_q16     o_n
);
    import aarm_pkg::*;

    logic [16:0] w_abs;
    logic [47:0] w_num;

    logic [31:0] r_rem0;
    logic [16:0] r_low0;
    logic [31:0] r_div0;
    logic        r_neg0;
    logic        r_zero0;

    logic [31:0] r_rem  [DIV_STEPS];
    logic [16:0] r_low  [DIV_STEPS];
    logic [16:0] r_quo  [DIV_STEPS];
    logic [31:0] r_div  [DIV_STEPS];
    logic        r_neg  [DIV_STEPS];
    logic        r_zero [DIV_STEPS];

    logic signed [17:0] w_qs;
    t_q16               r_n;

    // numerator |v| * 2^32 + r/2; quotient fits in 17 bits
    assign w_abs = i_v[15] ? -{i_v[15], i_v} : {i_v[15], i_v};
    assign w_num = {w_abs[15:0], 32'd0} + {17'd0, i_r[31:1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0  <= {1'b0, w_num[47:17]};
            r_low0  <= w_num[16:0];
            r_div0  <= i_r;
            r_neg0  <= i_v[15];
            r_zero0 <= (i_r == 32'd0);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [31:0] a_rem;
        logic [16:0] a_low;
        logic [16:0] a_quo;
        logic [31:0] a_div;
        logic        a_neg;
        logic        a_zero;
        logic [32:0] w_t;
        logic [31:0] n_rem;
        logic        n_bit;

        if (k == 0) begin : g_first
            assign a_rem  = r_rem0;
            assign a_low  = r_low0;
            assign a_quo  = '0;
            assign a_div  = r_div0;
            assign a_neg  = r_neg0;
            assign a_zero = r_zero0;
        end else begin : g_next
            assign a_rem  = r_rem[k-1];
            assign a_low  = r_low[k-1];
            assign a_quo  = r_quo[k-1];
            assign a_div  = r_div[k-1];
            assign a_neg  = r_neg[k-1];
            assign a_zero = r_zero[k-1];
        end

        assign w_t = {a_rem, a_low[16]};

        always_comb begin
            if (w_t >= {1'b0, a_div}) begin
                n_rem = 32'(w_t - {1'b0, a_div});
                n_bit = 1'b1;
            end else begin
                n_rem = w_t[31:0];
                n_bit = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= {a_low[15:0], 1'b0};
                r_quo[k]  <= {a_quo[15:0], n_bit};
                r_div[k]  <= a_div;
                r_neg[k]  <= a_neg;
                r_zero[k] <= a_zero;
            end
        end
    end

    // sign back on; zero-length vector gives zero
    assign w_qs = {1'b0, r_quo[DIV_STEPS-1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[DIV_STEPS-1]) begin
                r_n <= '0;
            end else if (r_neg[DIV_STEPS-1]) begin
                r_n <= -w_qs;
            end else begin
                r_n <= w_qs;
            end
        end
    end

    assign o_n = r_n;

endmodule
`default_nettype wire

### hdl/aarm_rot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_rot
// Matrix assembly: Rodrigues form for axis-angle requests, and the product
// Rz * Ry * Rx for Euler requests. Four register stages.
// ----------------------------------------------------------------------------
module aarm_rot (
    input  logic             i_clk,
    input  logic             i_en,
    input  aarm_pkg::t_op    i_op,
    input  aarm_pkg::t_nvec  i_n,
    input  aarm_pkg::t_sc3   i_sc,
    output aarm_pkg::t_ent   o_m [9]
);
    import aarm_pkg::*;

    // ---- stage A inputs, widened ----
    t_ent w_nx, w_ny, w_nz;
    t_ent w_s0, w_c0, w_s1, w_c1, w_t;
    t_ent w_rx [3][3];
    t_ent w_ry [3][3];

    // ---- stage A registers ----
    t_op                r_op_a;
    t_ent               r_p_a  [6];
    t_ent               r_sn_a [3];
    t_ent               r_t_a;
    t_ent               r_c_a;
    logic signed [39:0] r_pa   [3][3][3];
    t_sincos            r_sc2_a;

    // ---- stage B registers ----
    t_op     r_op_b;
    t_ent    r_pt_b [6];
    t_ent    r_sn_b [3];
    t_ent    r_c_b;
    t_ent    r_tmp_b [3][3];
    t_sincos r_sc2_b;

    // ---- stage C registers ----
    t_op                r_op_c;
    t_ent               r_e_c  [9];
    logic signed [39:0] r_pb_c [3][3][3];

    // ---- stage D ----
    t_ent w_rz [3][3];
    t_ent n_m  [9];
    t_ent r_m  [9];

    assign w_nx = t_ent'(i_n.x);
    assign w_ny = t_ent'(i_n.y);
    assign w_nz = t_ent'(i_n.z);
    assign w_s0 = t_ent'(i_sc.sc0.s);
    assign w_c0 = t_ent'(i_sc.sc0.c);
    assign w_s1 = t_ent'(i_sc.sc1.s);
    assign w_c1 = t_ent'(i_sc.sc1.c);
    assign w_t  = t_ent'(ONE) - w_c0;

    // single-axis factors, unit axis exact
    always_comb begin
        w_rx[0][0] = t_ent'(ONE); w_rx[0][1] = '0;    w_rx[0][2] = '0;
        w_rx[1][0] = '0;          w_rx[1][1] = w_c0;  w_rx[1][2] = -w_s0;
        w_rx[2][0] = '0;          w_rx[2][1] = w_s0;  w_rx[2][2] = w_c0;

        w_ry[0][0] = w_c1;        w_ry[0][1] = '0;    w_ry[0][2] = w_s1;
        w_ry[1][0] = '0;          w_ry[1][1] = t_ent'(ONE); w_ry[1][2] = '0;
        w_ry[2][0] = -w_s1;       w_ry[2][1] = '0;    w_ry[2][2] = w_c1;
    end

    // stage A: axis outer products and sine terms; Ry * Rx partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_a    <= i_op;
            r_p_a[0]  <= mulq(w_nx, w_nx);
            r_p_a[1]  <= mulq(w_ny, w_nx);
            r_p_a[2]  <= mulq(w_nz, w_nx);
            r_p_a[3]  <= mulq(w_ny, w_ny);
            r_p_a[4]  <= mulq(w_nz, w_ny);
            r_p_a[5]  <= mulq(w_nz, w_nz);
            r_sn_a[0] <= mulq(w_nx, w_s0);
            r_sn_a[1] <= mulq(w_ny, w_s0);
            r_sn_a[2] <= mulq(w_nz, w_s0);
            r_t_a     <= w_t;
            r_c_a     <= w_c0;
            r_sc2_a   <= i_sc.sc2;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_pa[i][j][k] <= 40'(w_ry[i][k]) * 40'(w_rx[k][j]);
                    end
                end
            end
        end
    end

    // stage B: scale by 1 - cos; round Ry * Rx
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_b  <= r_op_a;
            r_c_b   <= r_c_a;
            r_sc2_b <= r_sc2_a;
            for (int i = 0; i < 6; i++) begin
                r_pt_b[i] <= mulq(r_p_a[i], r_t_a);
            end
            for (int i = 0; i < 3; i++) begin
                r_sn_b[i] <= r_sn_a[i];
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_tmp_b[i][j] <= t_ent'((r_pa[i][j][0] + r_pa[i][j][1] + r_pa[i][j][2]
                                             + 40'sd32768) >>> 16);
                end
            end
        end
    end

    // Rz factor
    always_comb begin
        w_rz[0][0] = t_ent'(r_sc2_b.c);  w_rz[0][1] = -t_ent'(r_sc2_b.s); w_rz[0][2] = '0;
        w_rz[1][0] = t_ent'(r_sc2_b.s);  w_rz[1][1] = t_ent'(r_sc2_b.c);  w_rz[1][2] = '0;
        w_rz[2][0] = '0;                 w_rz[2][1] = '0;                 w_rz[2][2] = t_ent'(ONE);
    end

    // stage C: Rodrigues entries; Rz * (Ry * Rx) partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_c   <= r_op_b;
            r_e_c[0] <= r_pt_b[0] + r_c_b;
            r_e_c[1] <= r_pt_b[1] - r_sn_b[2];
            r_e_c[2] <= r_pt_b[2] + r_sn_b[1];
            r_e_c[3] <= r_pt_b[1] + r_sn_b[2];
            r_e_c[4] <= r_pt_b[3] + r_c_b;
            r_e_c[5] <= r_pt_b[4] - r_sn_b[0];
            r_e_c[6] <= r_pt_b[2] - r_sn_b[1];
            r_e_c[7] <= r_pt_b[4] + r_sn_b[0];
            r_e_c[8] <= r_pt_b[5] + r_c_b;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_pb_c[i][j][k] <= 40'(w_rz[i][k]) * 40'(r_tmp_b[k][j]);
                    end
                end
            end
        end
    end

    // stage D: round the Euler product and pick the result
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (r_op_c == OP_EULER) begin
                    n_m[i*3+j] = t_ent'((r_pb_c[i][j][0] + r_pb_c[i][j][1] + r_pb_c[i][j][2]
                                        + 40'sd32768) >>> 16);
                end else begin
                    n_m[i*3+j] = r_e_c[i*3+j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= n_m[i];
            end
        end
    end

    assign o_m = r_m;

endmodule
`default_nettype wire
